### design/square_matrix_multiply_assert.svh
`ifndef SQUARE_MATRIX_MULTIPLY_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_ASSERT_SVH

// Checked while out of reset.
`define SMM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("square_matrix_multiply: assertion failed");

// Checked at every edge, reset included.
`define SMM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("square_matrix_multiply: assertion failed");

`endif

### design/smm_pkg.sv
`timescale 1ns / 1ps
package smm_pkg;
   localparam int MAX_DIM_DEFAULT    = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int DIM_CFG_W          = 7;
   localparam int DIM_RESET          = 64;
   localparam int QUEUE_DEPTH        = 4;

   localparam logic CMD_B = 1'b0;
   localparam logic CMD_A = 1'b1;
endpackage

### design/smm_req_if.sv
`timescale 1ns / 1ps
interface smm_req_if #(
   parameter int DATA_W = smm_pkg::DATA_WIDTH_DEFAULT
);
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic signed [DATA_W-1:0] element_value;

   modport source (output valid, output cmd, output element_value, input ready);
   modport sink   (input valid, input cmd, input element_value, output ready);
endinterface

### design/smm_rsp_if.sv
`timescale 1ns / 1ps
interface smm_rsp_if #(
   parameter int DATA_W = smm_pkg::DATA_WIDTH_DEFAULT,
   parameter int IDX_W  = $clog2(smm_pkg::MAX_DIM_DEFAULT)
);
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] product_value;
   logic [IDX_W-1:0]         out_row;
   logic [IDX_W-1:0]         out_col;
   logic                     row_last;

   modport source (output valid, output product_value, output out_row, output out_col,
                   output row_last, input ready);
   modport sink   (input valid, input product_value, input out_row, input out_col,
                   input row_last, output ready);
endinterface

### design/square_matrix_multiply.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake       Carries
// req_ch    in         valid / ready   cmd, element_value
// rsp_ch    out        valid / ready   product_value, out_row, out_col, row_last
// csr       in         csr_we          csr_wdata (matrix dimension)
//
// A B element is written to the store as the idle back end takes it from the queue.
// An A element is worked there by a read, a multiply and an accumulate for each of
// the n columns on the one multiplier and the single-port accumulator memory.
// A four-entry queue lets the front end take requests while the back end works.
// Reset is synchronous; the B store holds nothing valid until it is loaded.
// The back end waits on the last element of a row while a result is not taken.
module square_matrix_multiply #(
   parameter int MAX_DIM = smm_pkg::MAX_DIM_DEFAULT,
   parameter int DATA_W  = smm_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [smm_pkg::DIM_CFG_W-1:0] csr_wdata,
   smm_req_if.sink                       req_ch,
   smm_rsp_if.source                     rsp_ch
);
   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int ENT_W = 2 + 2 * IDX_W + DATA_W;

   logic             push, queue_full, pop, head_valid;
   logic [ENT_W-1:0] push_entry, head_entry;
   logic [IDX_W-1:0] dim_m1;

   smm_front #(
      .MAX_DIM (MAX_DIM),
      .DATA_W  (DATA_W),
      .IDX_W   (IDX_W),
      .ENT_W   (ENT_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry),
      .dim_m1     (dim_m1)
   );

   smm_queue #(
      .WIDTH (ENT_W),
      .DEPTH (smm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_entry)
   );

   smm_back #(
      .MAX_DIM (MAX_DIM),
      .DATA_W  (DATA_W),
      .IDX_W   (IDX_W),
      .ENT_W   (ENT_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .dim_m1     (dim_m1),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );
endmodule

### design/smm_queue.sv
`timescale 1ns / 1ps
module smm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = smm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

### design/smm_front.sv
`timescale 1ns / 1ps
module smm_front #(
   parameter int MAX_DIM = smm_pkg::MAX_DIM_DEFAULT,
   parameter int DATA_W  = smm_pkg::DATA_WIDTH_DEFAULT,
   parameter int IDX_W   = $clog2(MAX_DIM),
   parameter int ENT_W   = 2 + 2 * IDX_W + DATA_W
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [smm_pkg::DIM_CFG_W-1:0]  csr_wdata,
   smm_req_if.sink                        req_ch,
   input  logic                           queue_full,
   output logic                           push,
   output logic [ENT_W-1:0]               push_entry,
   output logic [IDX_W-1:0]               dim_m1
);
   localparam int RESET_DIM = (smm_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM : smm_pkg::DIM_RESET;

   typedef struct packed {
      logic              is_a;
      logic              last;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] value;
   } entry_type;

   logic [IDX_W-1:0] dim_m1_ff, dim_m1_in;
   logic [IDX_W-1:0] b_row_ff, b_row_in, b_col_ff, b_col_in;
   logic [IDX_W-1:0] a_row_ff, a_row_in, a_col_ff, a_col_in;
   logic             accept, is_a;
   entry_type        entry;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;
   assign is_a         = (req_ch.cmd == smm_pkg::CMD_A);
   assign push         = accept;
   assign dim_m1       = dim_m1_ff;

   // A dimension of zero counts as one; anything above the maximum saturates.
   always_comb begin
      if (csr_wdata == '0) begin
         dim_m1_in = '0;
      end else if (int'(csr_wdata) > MAX_DIM) begin
         dim_m1_in = IDX_W'(MAX_DIM - 1);
      end else begin
         dim_m1_in = IDX_W'(csr_wdata - 1'b1);
      end
   end

   always_comb begin
      entry.is_a  = is_a;
      entry.value = req_ch.element_value;
      if (is_a) begin
         entry.last = (a_col_ff == dim_m1_ff);
         entry.row  = a_row_ff;
         entry.col  = a_col_ff;
      end else begin
         entry.last = 1'b0;
         entry.row  = b_row_ff;
         entry.col  = b_col_ff;
      end
   end
   assign push_entry = entry;

   always_comb begin
      b_row_in = b_row_ff;
      b_col_in = b_col_ff;
      a_row_in = a_row_ff;
      a_col_in = a_col_ff;
      if (accept && !is_a) begin
         if (b_col_ff == dim_m1_ff) begin
            b_col_in = '0;
            b_row_in = (b_row_ff == dim_m1_ff) ? '0 : b_row_ff + 1'b1;
         end else begin
            b_col_in = b_col_ff + 1'b1;
         end
      end
      if (accept && is_a) begin
         if (a_col_ff == dim_m1_ff) begin
            a_col_in = '0;
            a_row_in = (a_row_ff == dim_m1_ff) ? '0 : a_row_ff + 1'b1;
         end else begin
            a_col_in = a_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_m1_ff <= IDX_W'(RESET_DIM - 1);
         b_row_ff  <= '0;
         b_col_ff  <= '0;
         a_row_ff  <= '0;
         a_col_ff  <= '0;
      end else if (csr_we) begin
         // A new dimension restarts both loads.
         dim_m1_ff <= dim_m1_in;
         b_row_ff  <= '0;
         b_col_ff  <= '0;
         a_row_ff  <= '0;
         a_col_ff  <= '0;
      end else begin
         b_row_ff  <= b_row_in;
         b_col_ff  <= b_col_in;
         a_row_ff  <= a_row_in;
         a_col_ff  <= a_col_in;
      end
   end
endmodule

### design/smm_back.sv
`timescale 1ns / 1ps
module smm_back #(
   parameter int MAX_DIM = smm_pkg::MAX_DIM_DEFAULT,
   parameter int DATA_W  = smm_pkg::DATA_WIDTH_DEFAULT,
   parameter int IDX_W   = $clog2(MAX_DIM),
   parameter int ENT_W   = 2 + 2 * IDX_W + DATA_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] dim_m1,
   input  logic             head_valid,
   input  logic [ENT_W-1:0] head_entry,
   output logic             pop,
   smm_rsp_if.source        rsp_ch
);
   localparam int B_DEPTH = 1 << (2 * IDX_W);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_MUL  = 2'd2;
   localparam logic [1:0] ST_ACC  = 2'd3;

   typedef struct packed {
      logic              is_a;
      logic              last;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DATA_W-1:0] value;
   } entry_type;

   logic [DATA_W-1:0] b_mem   [B_DEPTH];
   logic [DATA_W-1:0] acc_mem [MAX_DIM];

   entry_type         head;
   logic [1:0]        state_ff, state_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic [DATA_W-1:0] value_ff;
   logic [IDX_W-1:0]  row_ff, k_ff;
   logic              last_k_ff;
   logic [DATA_W-1:0] b_rdata_ff, acc_rdata_ff, prod_ff, prev_ff, sum;
   logic              b_we, acc_we, take_a, advance, out_free, rsp_done;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff;
   logic [IDX_W-1:0]  rsp_row_ff, rsp_col_ff;
   logic              rsp_last_ff;

   assign head     = entry_type'(head_entry);
   assign pop      = (state_ff == ST_IDLE) && head_valid;
   assign b_we     = pop && !head.is_a;
   assign take_a   = pop && head.is_a;
   assign sum      = prev_ff + prod_ff;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_done = rsp_valid_ff && rsp_ch.ready;
   // On the last element of a row the sum leaves through the output register
   // instead of going back to the accumulators.
   assign advance  = (state_ff == ST_ACC) && (!last_k_ff || out_free);
   assign acc_we   = (state_ff == ST_ACC) && !last_k_ff;

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take_a) begin
               state_in = ST_READ;
               col_in   = '0;
            end
         end
         ST_READ: state_in = ST_MUL;
         ST_MUL:  state_in = ST_ACC;
         ST_ACC: begin
            if (advance) begin
               if (col_ff == dim_m1) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_READ;
                  col_in   = col_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_done) begin
         rsp_valid_in = 1'b0;
      end
      if (advance && last_k_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      if (take_a) begin
         value_ff  <= head.value;
         row_ff    <= head.row;
         k_ff      <= head.col;
         last_k_ff <= head.last;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= value_ff * b_rdata_ff;
         prev_ff <= (k_ff == '0) ? '0 : acc_rdata_ff;
      end
      if (advance && last_k_ff) begin
         rsp_value_ff <= sum;
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= col_ff;
         rsp_last_ff  <= (col_ff == dim_m1);
      end
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem[{head.row, head.col}] <= head.value;
      end
      b_rdata_ff <= b_mem[{k_ff, col_ff}];
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[col_ff] <= sum;
      end
      acc_rdata_ff <= acc_mem[col_ff];
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.product_value = rsp_value_ff;
   assign rsp_ch.out_row       = rsp_row_ff;
   assign rsp_ch.out_col       = rsp_col_ff;
   assign rsp_ch.row_last      = rsp_last_ff;
endmodule

### design/smm_checker.sv
`timescale 1ns / 1ps
`include "square_matrix_multiply_assert.svh"
module smm_checker #(
   parameter int DATA_W = smm_pkg::DATA_WIDTH_DEFAULT,
   parameter int IDX_W  = $clog2(smm_pkg::MAX_DIM_DEFAULT)
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_product_value,
   input logic [IDX_W-1:0]  rsp_out_row,
   input logic [IDX_W-1:0]  rsp_out_col,
   input logic              rsp_row_last
);
   // Column expected next: rows come out whole, from column zero upwards.
   logic [IDX_W-1:0] exp_col_ff, exp_col_in;

   assign exp_col_in = rsp_row_last ? '0 : rsp_out_col + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_col_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         exp_col_ff <= exp_col_in;
      end
   end

   `SMM_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid)
   `SMM_ASSERT(a_col_order, clock, reset, rsp_valid |-> rsp_out_col == exp_col_ff)
   `SMM_ASSERT(a_valid_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `SMM_ASSERT(a_payload_held, clock, reset,
      rsp_valid && !rsp_ready |=> $stable(rsp_product_value) && $stable(rsp_out_row))
endmodule

bind square_matrix_multiply smm_checker #(
   .DATA_W (DATA_W),
   .IDX_W  (IDX_W)
) u_smm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_product_value (rsp_ch.product_value),
   .rsp_out_row       (rsp_ch.out_row),
   .rsp_out_col       (rsp_ch.out_col),
   .rsp_row_last      (rsp_ch.row_last)
);
